// ===== src/olid_pkg.sv =====
// shared constants, codes and controller/datapath types for the ordered list
package olid_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 9;
  localparam int VAL_W = 32;

  localparam logic [1:0] MODE_TRAV  = 2'd0;
  localparam logic [1:0] MODE_FRONT = 2'd1;
  localparam logic [1:0] MODE_BACK  = 2'd2;
  localparam logic [1:0] MODE_DEL   = 2'd3;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_ELEMENT  = 3'd4;

  typedef struct packed {
    logic       ld_key;
    logic       cmp;
    logic       push_front;
    logic       push_back;
    logic       del;
    logic       trav_clr;
    logic       trav_inc;
    logic       res_ld;
    logic [2:0] res_status;
    logic       res_last;
  } olid_cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic full;
    logic found;
    logic trav_last;
    logic out_free;
  } olid_stat_t;

endpackage

// ===== src/olid_if.sv =====
// valid/ready channel interfaces for operation and result beats
interface olid_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          mode;
  logic signed [olid_pkg::VAL_W-1:0]   value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface olid_out_if;
  logic                                valid;
  logic                                ready;
  logic [2:0]                          status;
  logic [olid_pkg::POS_W-1:0]          position;
  logic signed [olid_pkg::VAL_W-1:0]   element;
  logic                                last;

  modport source (output valid, output status, output position, output element,
                  output last, input ready);
  modport sink   (input valid, input status, input position, input element,
                  input last, output ready);
endinterface

// ===== src/ordered_list_insert_delete.sv =====
// ordered list top: insert result is registered in the cycle after accept; delete steps key, compare, shift
// traverse gives one element beat per cycle while the output is free, occupancy beats
// throughput: one insert per cycle while the output is free; a delete or traverse holds off new operations
// until its last result is loaded, as the controller runs one operation at a time; output register decouples sink
// reset clears occupancy (empty list) and the sequencer; stored cells are not cleared
module ordered_list_insert_delete (
  input  logic         clk,
  input  logic         rst_n,
  olid_in_if.sink      in_ch,
  olid_out_if.source   out_ch
);

  olid_pkg::olid_cmd_t  cmd;
  olid_pkg::olid_stat_t stat;

  olid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  olid_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_value     (in_ch.value),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_status   (out_ch.status),
    .out_position (out_ch.position),
    .out_element  (out_ch.element),
    .out_last     (out_ch.last)
  );

endmodule

// ===== src/olid_ctrl.sv =====
// operation sequencer: accepts beats and drives datapath commands
module olid_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [1:0]           in_mode,
  output logic                 in_ready,
  input  olid_pkg::olid_stat_t stat,
  output olid_pkg::olid_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_DEL  = 2'd2;
  localparam logic [1:0] S_TRAV = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE) && stat.out_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = olid_pkg::ST_DONE;
    cmd.res_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        cmd.trav_clr = 1'b1;
        if (accept) begin
          case (in_mode)
            olid_pkg::MODE_TRAV: begin
              if (stat.occ_zero) begin
                cmd.res_ld     = 1'b1;
                cmd.res_status = olid_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_TRAV;
              end
            end
            olid_pkg::MODE_FRONT, olid_pkg::MODE_BACK: begin
              cmd.res_ld = 1'b1;
              if (stat.full) begin
                cmd.res_status = olid_pkg::ST_FULL;
              end else begin
                cmd.push_front = (in_mode == olid_pkg::MODE_FRONT);
                cmd.push_back  = (in_mode == olid_pkg::MODE_BACK);
              end
            end
            default: begin
              cmd.ld_key = 1'b1;
              state_nxt  = S_CMP;
            end
          endcase
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_DEL;
      end
      S_DEL: begin
        if (stat.out_free) begin
          cmd.res_ld = 1'b1;
          if (stat.found) begin
            cmd.del = 1'b1;
          end else begin
            cmd.res_status = olid_pkg::ST_NOTFOUND;
          end
          state_nxt = S_IDLE;
        end
      end
      S_TRAV: begin
        if (stat.out_free) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = olid_pkg::ST_ELEMENT;
          cmd.res_last   = stat.trav_last;
          cmd.trav_inc   = 1'b1;
          if (stat.trav_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/olid_dp.sv =====
// cell chain, occupancy, match mask, traverse index and result register
module olid_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic signed [olid_pkg::VAL_W-1:0] in_value,
  input  olid_pkg::olid_cmd_t               cmd,
  output olid_pkg::olid_stat_t              stat,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [olid_pkg::POS_W-1:0]        out_position,
  output logic signed [olid_pkg::VAL_W-1:0] out_element,
  output logic                              out_last
);

  logic signed [olid_pkg::VAL_W-1:0] cells_r   [olid_pkg::DEPTH];
  logic signed [olid_pkg::VAL_W-1:0] cells_nxt [olid_pkg::DEPTH];
  logic [olid_pkg::CNT_W-1:0]        occ_r;
  logic [olid_pkg::CNT_W-1:0]        occ_nxt;
  logic signed [olid_pkg::VAL_W-1:0] key_r;
  logic [olid_pkg::DEPTH-1:0]        hit;
  logic [olid_pkg::DEPTH-1:0]        mask_r;
  logic [olid_pkg::DEPTH-1:0]        mask_nxt;
  logic [olid_pkg::IDX_W-1:0]        trav_r;

  logic                              out_valid_r;
  logic [2:0]                        status_r;
  logic [olid_pkg::POS_W-1:0]        position_r;
  logic signed [olid_pkg::VAL_W-1:0] element_r;
  logic                              last_r;
  logic                              is_elem;

  assign stat.occ_zero  = (occ_r == '0);
  assign stat.full      = (occ_r == olid_pkg::CNT_W'(olid_pkg::DEPTH));
  assign stat.found     = mask_r[olid_pkg::DEPTH-1];
  assign stat.trav_last = ((olid_pkg::CNT_W'(trav_r) + 1'b1) == occ_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  // compare every live cell; mask marks the first match and every cell after it
  always_comb begin
    for (int j = 0; j < olid_pkg::DEPTH; j++) begin
      hit[j] = (cells_r[j] == key_r) && (olid_pkg::CNT_W'(j) < occ_r);
    end
    for (int j = 0; j < olid_pkg::DEPTH; j++) begin
      mask_nxt[j] = |(hit & ({olid_pkg::DEPTH{1'b1}} >> (olid_pkg::DEPTH - 1 - j)));
    end
  end

  always_comb begin
    cells_nxt = cells_r;
    occ_nxt   = occ_r;
    if (cmd.push_front) begin
      cells_nxt[0] = in_value;
      for (int j = 1; j < olid_pkg::DEPTH; j++) begin
        cells_nxt[j] = cells_r[j-1];
      end
      occ_nxt = occ_r + 1'b1;
    end else if (cmd.push_back) begin
      cells_nxt[occ_r[olid_pkg::IDX_W-1:0]] = in_value;
      occ_nxt = occ_r + 1'b1;
    end else if (cmd.del) begin
      // close the gap from the first match upward
      for (int j = 0; j < olid_pkg::DEPTH - 1; j++) begin
        if (mask_r[j]) begin
          cells_nxt[j] = cells_r[j+1];
        end
      end
      occ_nxt = occ_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cells_r <= cells_nxt;
    if (cmd.ld_key) begin
      key_r <= in_value;
    end
    if (cmd.cmp) begin
      mask_r <= mask_nxt;
    end
    if (cmd.trav_clr) begin
      trav_r <= '0;
    end else if (cmd.trav_inc) begin
      trav_r <= trav_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  assign is_elem = (cmd.res_status == olid_pkg::ST_ELEMENT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_ld) begin
      status_r   <= cmd.res_status;
      last_r     <= cmd.res_last;
      position_r <= is_elem ? (olid_pkg::POS_W'(trav_r) + 1'b1) : '0;
      element_r  <= is_elem ? cells_r[trav_r] : '0;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = status_r;
  assign out_position = position_r;
  assign out_element  = element_r;
  assign out_last     = last_r;

endmodule

// ===== src/olid_check.sv =====
// port-level checks for the ordered list, bound to the top level
module olid_check (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [2:0]                 out_status,
  input logic [olid_pkg::POS_W-1:0] out_position,
  input logic                       out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_position) && $stable(out_last))
    else $error("stalled result beat changed");

  // single-result operations carry no position and close the item
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != olid_pkg::ST_ELEMENT) |-> out_last && (out_position == '0))
    else $error("non-element result malformed");

  // element positions are 1-based and within capacity
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == olid_pkg::ST_ELEMENT) |->
      (out_position != '0) && (out_position <= olid_pkg::POS_W'(olid_pkg::DEPTH)))
    else $error("element position out of range");

  // mid-traverse no new operation is taken
  a_trav_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == olid_pkg::ST_ELEMENT) && !out_last |->
      !(in_valid && in_ready))
    else $error("operation accepted during traverse");

endmodule

bind ordered_list_insert_delete olid_check u_olid_check (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_status   (out_ch.status),
  .out_position (out_ch.position),
  .out_last     (out_ch.last)
);
